>>> rtl/core/lfsq_pkg.sv
// Shared types and constants for the largest free square finder.
`timescale 1ns / 1ps

package lfsq_pkg;

  localparam int CHAR_W    = 8;
  localparam int DIM_W     = 11;
  localparam int SIZE_W    = 11;
  localparam int POS_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [DIM_W-1:0]  RST_ROW_WIDTH = DIM_W'(1024);
  localparam logic [DIM_W-1:0]  RST_ROW_COUNT = DIM_W'(1024);
  localparam logic [CHAR_W-1:0] RST_OBSTACLE  = CHAR_W'(111);
  localparam logic [SIZE_W-1:0] SIZE_SAT      = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH = 2'd0,
    REG_ROW_COUNT = 2'd1,
    REG_OBSTACLE  = 2'd2
  } cfg_reg_t;

  // Per-cell control handed from the scan front end to the size stage
  typedef struct packed {
    logic is_free;
    logic border;    // first row or first column
    logic row_end;
    logic grid_end;
  } cell_ctl_t;

endpackage

>>> rtl/core/lfsq_line_buf.sv
// Line buffer memory holding the previous row's square sizes.
`timescale 1ns / 1ps

module lfsq_line_buf
  import lfsq_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  rd_addr,
  output logic [SIZE_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [COL_W-1:0]  wr_addr,
  input  logic [SIZE_W-1:0] wr_data
);

  logic [SIZE_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

>>> rtl/core/lfsq_scan_ctrl.sv
// Raster position counters, cell classification and the size-stage input register.
`timescale 1ns / 1ps

module lfsq_scan_ctrl
  import lfsq_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [DIM_W-1:0]  row_width,
  input  logic [DIM_W-1:0]  row_count,
  input  logic [CHAR_W-1:0] obstacle_char,
  input  logic              accept,
  input  logic [CHAR_W-1:0] cell_char,
  input  logic              retire,
  output logic [COL_W-1:0]  col_count,
  output logic              s2_valid,
  output cell_ctl_t         s2_ctl,
  output logic [COL_W-1:0]  s2_col,
  output logic [ROW_W-1:0]  s2_row
);

  localparam int CW_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  localparam int RW_W = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;

  logic [ROW_W-1:0] row_index;
  logic [CW_W-1:0]  width_raw, width_eff, col_p1;
  logic [RW_W-1:0]  count_raw, count_eff, row_p1;
  logic             row_end, grid_end;

  // Zero counts as one, anything above MAX_WIDTH / MAX_HEIGHT saturates
  always_comb begin
    width_raw = CW_W'(row_width);
    count_raw = RW_W'(row_count);
    if (width_raw == '0) begin
      width_eff = CW_W'(1);
    end else if (width_raw > CW_W'(MAX_WIDTH)) begin
      width_eff = CW_W'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    if (count_raw == '0) begin
      count_eff = RW_W'(1);
    end else if (count_raw > RW_W'(MAX_HEIGHT)) begin
      count_eff = RW_W'(MAX_HEIGHT);
    end else begin
      count_eff = count_raw;
    end
    col_p1   = CW_W'(col_count) + CW_W'(1);
    row_p1   = RW_W'(row_index) + RW_W'(1);
    row_end  = (col_p1 >= width_eff);
    grid_end = row_end && (row_p1 >= count_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_index <= '0;
      s2_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (!row_end) begin
          col_count <= COL_W'(col_p1);
        end else begin
          col_count <= '0;
          row_index <= grid_end ? '0 : ROW_W'(row_p1);
        end
        s2_valid <= 1'b1;
      end else if (retire) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_ctl.is_free  <= (cell_char != obstacle_char);
      s2_ctl.border   <= (row_index == '0) || (col_count == '0);
      s2_ctl.row_end  <= row_end;
      s2_ctl.grid_end <= grid_end;
      s2_col          <= col_count;
      s2_row          <= row_index;
    end
  end

endmodule

>>> rtl/core/lfsq_best_track.sv
// Square size update, best-square tracking and the result register.
`timescale 1ns / 1ps

module lfsq_best_track
  import lfsq_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s2_valid,
  input  cell_ctl_t         s2_ctl,
  input  logic [COL_W-1:0]  s2_col,
  input  logic [ROW_W-1:0]  s2_row,
  input  logic [SIZE_W-1:0] up_size,
  output logic              retire,
  output logic [SIZE_W-1:0] size,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              found,
  output logic [SIZE_W-1:0] best_size,
  output logic [POS_W-1:0]  best_col,
  output logic [POS_W-1:0]  best_row
);

  logic [SIZE_W-1:0] left_size, diag_size, min_size;
  logic [SIZE_W-1:0] top_size, top_size_next;
  logic [COL_W-1:0]  top_col, top_col_next;
  logic [ROW_W-1:0]  top_row, top_row_next;

  // Hold the stage only when a finished grid meets a result still waiting
  assign retire = s2_valid && !(s2_ctl.grid_end && result_valid && result_stall);

  always_comb begin
    min_size = (up_size < diag_size) ? up_size : diag_size;
    min_size = (min_size < left_size) ? min_size : left_size;
    if (!s2_ctl.is_free) begin
      size = '0;
    end else if (s2_ctl.border) begin
      size = SIZE_W'(1);
    end else if (min_size == SIZE_SAT) begin
      size = SIZE_SAT;
    end else begin
      size = min_size + SIZE_W'(1);
    end
    top_size_next = top_size;
    top_col_next  = top_col;
    top_row_next  = top_row;
    // Strictly larger only: earliest cell keeps a tie
    if (size > top_size) begin
      top_size_next = size;
      top_col_next  = s2_col;
      top_row_next  = s2_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size    <= '0;
      diag_size    <= '0;
      top_size     <= '0;
      top_col      <= '0;
      top_row      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (retire) begin
        if (s2_ctl.row_end) begin
          left_size <= '0;
          diag_size <= '0;
        end else begin
          left_size <= size;
          diag_size <= up_size;
        end
        if (s2_ctl.grid_end) begin
          top_size <= '0;
          top_col  <= '0;
          top_row  <= '0;
        end else begin
          top_size <= top_size_next;
          top_col  <= top_col_next;
          top_row  <= top_row_next;
        end
      end
      if (retire && s2_ctl.grid_end) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire && s2_ctl.grid_end) begin
      found     <= (top_size_next != '0);
      best_size <= top_size_next;
      best_col  <= POS_W'(top_col_next);
      best_row  <= POS_W'(top_row_next);
    end
  end

endmodule

>>> rtl/core/largest_free_square_finder.sv
// Result: registered when the grid's last cell retires from the size stage.
// Throughput: one cell per cycle unless stalled; the line buffer is read on accept
//   and written on retire, at a different entry unless the row is one cell.
// Cells stall only while a finished result waits and the next grid also ends.
// Reset: synchronous; registers return to 1024 / 1024 / 111, position and the
//   running best clear at once; the line buffer is not cleared (row 0 ignores it).
`timescale 1ns / 1ps

module largest_free_square_finder
  import lfsq_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 cell_valid,
  output logic                 cell_stall,
  input  logic [CHAR_W-1:0]    cell_char,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 found,
  output logic [SIZE_W-1:0]    best_size,
  output logic [POS_W-1:0]     best_col,
  output logic [POS_W-1:0]     best_row
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [DIM_W-1:0]  row_width, row_count;
  logic [CHAR_W-1:0] obstacle_char;
  logic              accept, retire, s2_valid;
  cell_ctl_t         s2_ctl;
  logic [COL_W-1:0]  col_count, s2_col;
  logic [ROW_W-1:0]  s2_row;
  logic [SIZE_W-1:0] up_size, size;

  assign cfg_ready  = 1'b1;
  assign cell_stall = s2_valid && !retire;
  assign accept     = cell_valid && !cell_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width     <= RST_ROW_WIDTH;
      row_count     <= RST_ROW_COUNT;
      obstacle_char <= RST_OBSTACLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH: row_width     <= cfg_data;
        REG_ROW_COUNT: row_count     <= cfg_data;
        REG_OBSTACLE:  obstacle_char <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  lfsq_scan_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COL_W     (COL_W),
    .ROW_W     (ROW_W)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .row_width    (row_width),
    .row_count    (row_count),
    .obstacle_char(obstacle_char),
    .accept       (accept),
    .cell_char    (cell_char),
    .retire       (retire),
    .col_count    (col_count),
    .s2_valid     (s2_valid),
    .s2_ctl       (s2_ctl),
    .s2_col       (s2_col),
    .s2_row       (s2_row)
  );

  lfsq_line_buf #(
    .MAX_WIDTH(MAX_WIDTH),
    .COL_W    (COL_W)
  ) u_line_buf (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(col_count),
    .rd_data(up_size),
    .wr_en  (retire),
    .wr_addr(s2_col),
    .wr_data(size)
  );

  lfsq_best_track #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COL_W     (COL_W),
    .ROW_W     (ROW_W)
  ) u_best (
    .clk         (clk),
    .rst         (rst),
    .s2_valid    (s2_valid),
    .s2_ctl      (s2_ctl),
    .s2_col      (s2_col),
    .s2_row      (s2_row),
    .up_size     (up_size),
    .retire      (retire),
    .size        (size),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .found       (found),
    .best_size   (best_size),
    .best_col    (best_col),
    .best_row    (best_row)
  );

endmodule
